// File: hdl/largest_empty_square_finder_core_assert.svh
// Assertion macros for the largest empty square finder RTL.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_CORE_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_CORE_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define LESF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LESF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/lesf_pkg.sv
// Shared types and constants of the largest empty square finder.
package lesf_pkg;

    localparam int CHAR_W          = 8;
    localparam int CNT_W           = 10;
    localparam int SIZE_W          = 11;
    localparam int MAX_DIM         = 1024;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 11;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 32;

    localparam logic [SIZE_W-1:0] GRID_ROWS_RST = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] GRID_COLS_RST = SIZE_W'(1);
    localparam logic [CHAR_W-1:0] OBSTACLE_RST  = CHAR_W'(111);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS = 2'd0,
        CFG_GRID_COLS = 2'd1,
        CFG_OBSTACLE  = 2'd2
    } cfg_index_t;

    // Cell in flight between the read issue and the update stage
    typedef struct packed {
        logic             valid;
        logic             empty;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last_col;
        logic             last_grid;
    } cell_stage_t;

    // Stage control from the update stage back to the sequencer
    typedef struct packed {
        logic out_full;
        logic hold;
    } stage_ctrl_t;

endpackage

// File: hdl/lesf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read (read-first).
module lesf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, returns old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/lesf_seq.sv
// Raster position tracking, row-store read issue and the stage register.
module lesf_seq
    import lesf_pkg::*;
#(
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] cell_char,
    input  logic [SIZE_W-1:0] eff_rows,
    input  logic [SIZE_W-1:0] eff_cols,
    input  logic [CHAR_W-1:0] obstacle_char,
    input  stage_ctrl_t       ctrl,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output cell_stage_t       stage
);

    logic [CNT_W-1:0] row_count_reg, row_count_next;
    logic [CNT_W-1:0] col_count_reg, col_count_next;
    cell_stage_t      stage_reg, stage_next;
    logic             accept;
    logic             last_col;
    logic             last_row;
    logic [SIZE_W-1:0] col_inc;
    logic [SIZE_W-1:0] row_inc;

    // Hold off while a finished grid waits for a free output register
    assign s_tready = !(stage_reg.valid && stage_reg.last_grid && ctrl.out_full);
    assign accept   = s_tvalid && s_tready;

    assign col_inc  = SIZE_W'(col_count_reg) + SIZE_W'(1);
    assign row_inc  = SIZE_W'(row_count_reg) + SIZE_W'(1);
    assign last_col = (col_inc >= eff_cols);
    assign last_row = (row_inc >= eff_rows);

    // Previous-row read for the accepted cell
    assign rd_en   = accept;
    assign rd_addr = col_count_reg[ADDR_W-1:0];

    // Position counters
    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (accept) begin
            if (last_col) begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : CNT_W'(row_inc);
            end else begin
                col_count_next = CNT_W'(col_inc);
            end
        end
    end

    // Stage register, frozen while the update stage holds
    always_comb begin
        stage_next = stage_reg;
        if (!ctrl.hold) begin
            stage_next.valid     = accept;
            stage_next.empty     = (cell_char != obstacle_char);
            stage_next.row       = row_count_reg;
            stage_next.col       = col_count_reg;
            stage_next.last_col  = last_col;
            stage_next.last_grid = last_col && last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            stage_reg     <= '0;
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            stage_reg     <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

// File: hdl/lesf_update.sv
// Square-size update, row-store write-back with forwarding, best tracking and result register.
module lesf_update
    import lesf_pkg::*;
#(
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_stage_t       stage,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic [SIZE_W-1:0] rd_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [SIZE_W-1:0] wr_data,
    output stage_ctrl_t       ctrl,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              found,
    output logic [CNT_W-1:0]  top_row,
    output logic [CNT_W-1:0]  left_col,
    output logic [SIZE_W-1:0] square_size
);

    logic [SIZE_W-1:0] left_size_reg, left_size_next;
    logic [SIZE_W-1:0] diag_size_reg, diag_size_next;
    logic [SIZE_W-1:0] best_size_reg, best_size_next;
    logic [CNT_W-1:0]  best_top_reg, best_top_next;
    logic [CNT_W-1:0]  best_left_reg, best_left_next;
    logic              fwd_reg;
    logic [SIZE_W-1:0] fwd_data_reg;
    logic              m_valid_reg, m_valid_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    logic              advance;
    logic              row0;
    logic              col0;
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] left;
    logic [SIZE_W-1:0] diag;
    logic [SIZE_W-1:0] min_lu;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] cur;
    logic              better;
    logic [SIZE_W-1:0] cand_top;
    logic [SIZE_W-1:0] cand_left;

    // A finished grid stays put until the result register is free
    assign ctrl.out_full = m_valid_reg;
    assign ctrl.hold     = stage.valid && stage.last_grid && m_valid_reg && !m_tready;
    assign advance       = stage.valid && !ctrl.hold;

    // Neighbour sizes; the row store is bypassed when the last write hit the read entry
    assign row0 = (stage.row == '0);
    assign col0 = (stage.col == '0);
    assign up   = row0 ? '0 : (fwd_reg ? fwd_data_reg : rd_data);
    assign left = col0 ? '0 : left_size_reg;
    assign diag = (col0 || row0) ? '0 : diag_size_reg;

    // Three-way minimum plus one, zero on an obstacle
    assign min_lu  = (left < up) ? left : up;
    assign min_all = (min_lu < diag) ? min_lu : diag;
    assign cur     = stage.empty ? (min_all + SIZE_W'(1)) : '0;

    // Row-store write-back
    assign wr_en   = advance;
    assign wr_addr = stage.col[ADDR_W-1:0];
    assign wr_data = cur;

    // Top-left corner of the candidate, worked out beside the compare
    assign better    = (cur > best_size_reg);
    assign cand_top  = SIZE_W'(stage.row) + SIZE_W'(1) - cur;
    assign cand_left = SIZE_W'(stage.col) + SIZE_W'(1) - cur;

    // Running state of the grid
    always_comb begin
        left_size_next = left_size_reg;
        diag_size_next = diag_size_reg;
        best_size_next = best_size_reg;
        best_top_next  = best_top_reg;
        best_left_next = best_left_reg;
        if (advance) begin
            left_size_next = stage.last_col ? '0 : cur;
            diag_size_next = stage.last_col ? '0 : up;
            if (better) begin
                best_size_next = cur;
                best_top_next  = cand_top[CNT_W-1:0];
                best_left_next = cand_left[CNT_W-1:0];
            end
            if (stage.last_grid) begin
                best_size_next = '0;
                best_top_next  = '0;
                best_left_next = '0;
            end
        end
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        found_next   = found_reg;
        top_next     = top_reg;
        left_next    = left_reg;
        size_next    = size_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (advance && stage.last_grid) begin
            m_valid_next = 1'b1;
            if (better) begin
                found_next = 1'b1;
                top_next   = cand_top[CNT_W-1:0];
                left_next  = cand_left[CNT_W-1:0];
                size_next  = cur;
            end else begin
                found_next = (best_size_reg != '0);
                top_next   = best_top_reg;
                left_next  = best_left_reg;
                size_next  = best_size_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_size_reg <= '0;
            diag_size_reg <= '0;
            best_size_reg <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
            fwd_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            left_size_reg <= left_size_next;
            diag_size_reg <= diag_size_next;
            best_size_reg <= best_size_next;
            best_top_reg  <= best_top_next;
            best_left_reg <= best_left_next;
            m_valid_reg   <= m_valid_next;
            // Same entry read and written in one cycle: the RAM returns old data
            if (rd_en) begin
                fwd_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        fwd_data_reg <= wr_data;
        found_reg    <= found_next;
        top_reg      <= top_next;
        left_reg     <= left_next;
        size_reg     <= size_next;
    end

    assign m_tvalid    = m_valid_reg;
    assign found       = found_reg;
    assign top_row     = top_reg;
    assign left_col    = left_reg;
    assign square_size = size_reg;

`include "largest_empty_square_finder_core_assert.svh"

    `LESF_ASSERT(a_cur_bounded, stage.valid |-> (cur <= SIZE_W'(stage.col) + SIZE_W'(1) && cur <= SIZE_W'(stage.row) + SIZE_W'(1)), "square size exceeds its position")
    `LESF_ASSERT(a_best_grows, (advance && !stage.last_grid) |=> (best_size_reg >= $past(best_size_reg)), "best size shrank within a grid")
    `LESF_ASSERT(a_none_is_zero, (m_valid_reg && !found_reg) |-> (top_reg == '0 && left_reg == '0 && size_reg == '0), "empty result carries a position")
    `LESF_ASSERT_ALWAYS(a_hold_only_full, ctrl.hold |-> m_valid_reg, "stage held with a free result register")

endmodule

// File: hdl/largest_empty_square_finder_core.sv
// Largest empty square finder: streams grid cells in raster order and reports the largest
// obstacle-free square. One cell is taken every cycle while s_tready is high. The previous row
// of square sizes lives in one RAM that is read when a cell is accepted and written back
// from the update stage after the stage register, with a bypass when consecutive cells share
// a column. The result is registered when the last cell of a grid leaves the update stage;
// while a result is still waiting to be taken, the stream pauses once the next grid's last
// cell reaches the update stage. No clearing pass after reset.
module largest_empty_square_finder_core
    import lesf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // cell stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] cell_char
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] top_row, [19:10] left_col, [30:20] square_size
    output logic                  m_tuser    // [0] found
);

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [SIZE_W-1:0] DIM_MAX = SIZE_W'(MAX_DIM);

    logic [SIZE_W-1:0] grid_rows_reg, grid_rows_next;
    logic [SIZE_W-1:0] grid_cols_reg, grid_cols_next;
    logic [CHAR_W-1:0] obstacle_reg, obstacle_next;
    logic [SIZE_W-1:0] eff_rows;
    logic [SIZE_W-1:0] eff_cols;
    logic              cfg_write;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [SIZE_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SIZE_W-1:0] wr_data;
    cell_stage_t       stage;
    stage_ctrl_t       ctrl;

    logic              found;
    logic [CNT_W-1:0]  top_row;
    logic [CNT_W-1:0]  left_col;
    logic [SIZE_W-1:0] square_size;

    // Configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        obstacle_next  = obstacle_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_GRID_ROWS: grid_rows_next = cfg_data;
                CFG_GRID_COLS: grid_cols_next = cfg_data;
                CFG_OBSTACLE:  obstacle_next  = cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= GRID_ROWS_RST;
            grid_cols_reg <= GRID_COLS_RST;
            obstacle_reg  <= OBSTACLE_RST;
        end else begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
            obstacle_reg  <= obstacle_next;
        end
    end

    // Zero acts as one, oversize clamps to the store depth
    assign eff_rows = (grid_rows_reg == '0) ? SIZE_W'(1) :
                      (grid_rows_reg > DIM_MAX) ? DIM_MAX : grid_rows_reg;
    assign eff_cols = (grid_cols_reg == '0) ? SIZE_W'(1) :
                      (grid_cols_reg > DIM_MAX) ? DIM_MAX : grid_cols_reg;

    lesf_seq #(
        .ADDR_W (ADDR_W)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .cell_char     (s_tdata[CHAR_W-1:0]),
        .eff_rows      (eff_rows),
        .eff_cols      (eff_cols),
        .obstacle_char (obstacle_reg),
        .ctrl          (ctrl),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .stage         (stage)
    );

    // Previous row of square sizes
    lesf_ram #(
        .WIDTH  (SIZE_W),
        .DEPTH  (MAX_DIM),
        .ADDR_W (ADDR_W)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lesf_update #(
        .ADDR_W (ADDR_W)
    ) u_update (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stage       (stage),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .ctrl        (ctrl),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .found       (found),
        .top_row     (top_row),
        .left_col    (left_col),
        .square_size (square_size)
    );

    // Result packing
    assign m_tdata = {{(M_TDATA_W - 2 * CNT_W - SIZE_W){1'b0}}, square_size, left_col, top_row};
    assign m_tuser = found;

endmodule
